// ===== rtl/rhcc_pkg.sv =====
// Package with shared types, constants and the divider cell step for the colour converter.
`default_nettype none
package rhcc_pkg;
    localparam int unsigned SECTOR    = 3840;
    localparam int unsigned TURN      = 23040;
    localparam int unsigned ONE_Q16   = 65536;
    localparam int unsigned QW        = 17;   // quotient bits (covers 0..65536 and 0..23039)
    localparam int unsigned DW        = 8;    // divisor width
    localparam int unsigned NW        = 34;   // dividend width: up to 65536*255 or 23040*255

    localparam logic KIND_TO_HSV = 1'b0;
    localparam logic KIND_TO_RGB = 1'b1;

    // Work carried along the chain of division cells.
    typedef struct packed {
        logic          kind;
        logic [NW-1:0] hnum;
        logic [NW-1:0] snum;
        logic [DW-1:0] hden;
        logic [DW-1:0] sden;
        logic [QW-1:0] hq;
        logic [QW-1:0] sq;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic [7:0]    v;
    } work_t;

    typedef struct packed {
        logic [QW-1:0] rem;
        logic          bit_q;
    } div_step_t;

    // One restoring-division step: shift in the next dividend bit, compare, subtract.
    function automatic div_step_t div_step(input logic [QW-1:0] rem,
                                           input logic nbit,
                                           input logic [DW-1:0] den);
        logic [QW:0] trial;
        div_step_t   res;
        trial = {rem, nbit};
        if (trial >= {{(QW+1-DW){1'b0}}, den})
        begin
            trial     = trial - {{(QW+1-DW){1'b0}}, den};
            res.bit_q = 1'b1;
        end
        else
        begin
            res.bit_q = 1'b0;
        end
        res.rem = trial[QW-1:0];
        return res;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/rhcc_div_cell.sv =====
// One cell of the division chain: two quotient bits (hue and saturation) per cycle while en is high.
`default_nettype none
module rhcc_div_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic [4:0]      bit_idx,
    input  wire rhcc_pkg::work_t in_work,
    input  wire logic [rhcc_pkg::QW-1:0] in_hrem,
    input  wire logic [rhcc_pkg::QW-1:0] in_srem,
    input  wire logic            in_valid,
    output rhcc_pkg::work_t      out_work,
    output logic [rhcc_pkg::QW-1:0] out_hrem,
    output logic [rhcc_pkg::QW-1:0] out_srem,
    output logic                 out_valid
);
    import rhcc_pkg::*;

    work_t     work_next;
    div_step_t hs;
    div_step_t ss;
    work_t     work_reg;
    logic [QW-1:0] hrem_reg;
    logic [QW-1:0] srem_reg;
    logic      valid_reg;
    logic [QW-1:0] hlow;
    logic [QW-1:0] slow;

    // Only the low QW dividend bits are shifted in; the upper bits seed the remainder.
    always_comb
    begin
        hlow = in_work.hnum[QW-1:0];
        slow = in_work.snum[QW-1:0];
        hs = div_step(in_hrem, hlow[bit_idx], in_work.hden);
        ss = div_step(in_srem, slow[bit_idx], in_work.sden);
        work_next    = in_work;
        work_next.hq = {in_work.hq[QW-2:0], hs.bit_q};
        work_next.sq = {in_work.sq[QW-2:0], ss.bit_q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
            hrem_reg <= hs.rem;
            srem_reg <= ss.rem;
        end
    end

    assign out_work  = work_reg;
    assign out_hrem  = hrem_reg;
    assign out_srem  = srem_reg;
    assign out_valid = valid_reg;
endmodule
`default_nettype wire

// ===== rtl/rhcc_hsv2rgb.sv =====
// Two-stage HSV to RGB datapath: products first, then rounding and sector select.
`default_nettype none
module rhcc_hsv2rgb (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [14:0] hue,
    input  wire logic [16:0] saturation,
    input  wire logic [7:0]  brightness,
    output logic [7:0]       r,
    output logic [7:0]       g,
    output logic [7:0]       b
);
    import rhcc_pkg::*;

    localparam logic [39:0] DEN  = 40'(SECTOR) * 40'(ONE_Q16);
    localparam logic [39:0] HALF = DEN >> 1;
    localparam logic [12:0] RECIP15 = 13'd4370;

    logic [14:0] hw;
    logic [16:0] sc;
    logic [2:0]  sec;
    logic [11:0] f;
    logic [28:0] fp;
    logic [28:0] fq;
    logic [28:0] ft;
    logic [28:0] pk_reg;
    logic [28:0] qk_reg;
    logic [28:0] tk_reg;
    logic [2:0]  sec_reg;
    logic [7:0]  v_reg;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [39:0] np;
    logic [39:0] nq;
    logic [39:0] nt;
    logic [11:0] xp;
    logic [11:0] xq;
    logic [11:0] xt;

    always_comb
    begin
        hw  = (hue >= 15'(TURN)) ? 15'(hue - 15'(TURN)) : hue;
        sc  = (saturation > 17'(ONE_Q16)) ? 17'(ONE_Q16) : saturation;
        // Sector found by comparing against the sector boundaries.
        if (hw >= 15'(5 * SECTOR))
            sec = 3'd5;
        else if (hw >= 15'(4 * SECTOR))
            sec = 3'd4;
        else if (hw >= 15'(3 * SECTOR))
            sec = 3'd3;
        else if (hw >= 15'(2 * SECTOR))
            sec = 3'd2;
        else if (hw >= 15'(SECTOR))
            sec = 3'd1;
        else
            sec = 3'd0;
        f   = 12'(hw - 15'(sec) * 15'(SECTOR));
        fp  = 29'(DEN) - 29'(sc) * 29'(SECTOR);
        fq  = 29'(DEN) - 29'(sc) * 29'(f);
        ft  = 29'(DEN) - 29'(sc) * 29'(12'(SECTOR) - f);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pk_reg  <= fp;
            qk_reg  <= fq;
            tk_reg  <= ft;
            sec_reg <= sec;
            v_reg   <= brightness;
        end
    end

    always_comb
    begin
        np = 40'(pk_reg) * 40'(v_reg) + HALF;
        nq = 40'(qk_reg) * 40'(v_reg) + HALF;
        nt = 40'(tk_reg) * 40'(v_reg) + HALF;
        // Dividing by 3840*65536 is a shift by 24 then a division by 15 on a value
        // below 3840; that division is a multiply by 4370 and a shift by 16, exact
        // for every value below 4681.
        xp = 12'(np >> 24);
        xq = 12'(nq >> 24);
        xt = 12'(nt >> 24);
        p = 8'((25'(xp) * 25'(RECIP15)) >> 16);
        q = 8'((25'(xq) * 25'(RECIP15)) >> 16);
        t = 8'((25'(xt) * 25'(RECIP15)) >> 16);
        case (sec_reg)
            3'd0:    begin r = v_reg; g = t;     b = p;     end
            3'd1:    begin r = q;     g = v_reg; b = p;     end
            3'd2:    begin r = p;     g = v_reg; b = t;     end
            3'd3:    begin r = p;     g = q;     b = v_reg; end
            3'd4:    begin r = t;     g = p;     b = v_reg; end
            default: begin r = v_reg; g = p;     b = q;     end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/rgb_hsv_color_converter_top.sv =====
// Top level of the RGB/HSV pixel converter: front end, division cell chain, output register.
// Path from an accepted request to its result: one set-up stage, seventeen division cells
//   each retiring one bit of each quotient, and one output register.
// Throughput: one request per cycle while the chain is not halted; every cell holds a different pixel.
// The whole chain advances together and halts only when the output register is full
//   and not being taken downstream.
// Reset (rst_n, asynchronous, active low) clears every valid flag; the data registers are not reset.
`default_nettype none
module rgb_hsv_color_converter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // red[7:0], green[7:0], blue[7:0], hue[14:0],
                                       // saturation[16:0], brightness[7:0]
    input  wire logic        s_tuser,  // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata   // out_red, out_green, out_blue, out_hue[14:0],
                                       // out_saturation[16:0], out_brightness[7:0]
);
    import rhcc_pkg::*;

    localparam int unsigned NC = QW;

    logic en;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [7:0]  brightness;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [NW-1:0] hnum;
    work_t       w0_next;
    work_t       w0_reg;
    logic        v0_reg;
    logic [7:0]  cr;
    logic [7:0]  cg;
    logic [7:0]  cb;

    work_t       cw   [NC+1];
    logic [QW-1:0] chr[NC+1];
    logic [QW-1:0] csr[NC+1];
    logic        cv   [NC+1];

    logic        ov_reg;
    logic [63:0] od_reg;
    logic [63:0] od_next;

    // Whole pipeline moves while the output slot is free or being drained.
    assign en       = !ov_reg || m_tready;
    assign s_tready = en;

    assign red        = s_tdata[7:0];
    assign green      = s_tdata[15:8];
    assign blue       = s_tdata[23:16];
    assign hue        = s_tdata[38:24];
    assign saturation = s_tdata[55:39];
    assign brightness = s_tdata[63:56];

    // Set-up: find max and min and form the hue and saturation dividends.
    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        d = mx - mn;
        if (mx == red)
        begin
            if (green >= blue)
                hnum = NW'(SECTOR) * NW'(green - blue);
            else
                hnum = NW'(TURN) * NW'(d) - NW'(SECTOR) * NW'(blue - green);
        end
        else if (mx == green)
            hnum = NW'(2 * SECTOR) * NW'(d) + NW'(SECTOR) * NW'(blue) - NW'(SECTOR) * NW'(red);
        else
            hnum = NW'(4 * SECTOR) * NW'(d) + NW'(SECTOR) * NW'(red) - NW'(SECTOR) * NW'(green);

        w0_next      = '0;
        w0_next.kind = s_tuser;
        w0_next.v    = mx;
        // A zero divisor is replaced by a zero dividend over one, which yields zero.
        w0_next.hnum = (d == 8'd0) ? '0 : hnum;
        w0_next.hden = (d == 8'd0) ? 8'd1 : d;
        w0_next.snum = (mx == 8'd0) ? '0 : (NW'(d) << 16);
        w0_next.sden = (mx == 8'd0) ? 8'd1 : mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w0_reg <= w0_next;
    end

    // The dividends are below 2^QW times the divisor, so the high bits contribute
    // the initial remainder directly.
    assign cw[0]  = w0_reg;
    assign chr[0] = w0_reg.hnum[NW-1:QW];
    assign csr[0] = w0_reg.snum[NW-1:QW];
    assign cv[0]  = v0_reg;

    genvar i;
    generate
        for (i = 0; i < NC; i++)
        begin : g_cell
            rhcc_div_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .bit_idx  (5'(QW - 1 - i)),
                .in_work  (cw[i]),
                .in_hrem  (chr[i]),
                .in_srem  (csr[i]),
                .in_valid (cv[i]),
                .out_work (cw[i+1]),
                .out_hrem (chr[i+1]),
                .out_srem (csr[i+1]),
                .out_valid(cv[i+1])
            );
        end
    endgenerate

    // The RGB path runs beside the last cell in time: a delay line feeds it so that
    // its own register holds the same pixel as the chain end.
    logic [14:0] hue_d  [NC-1];
    logic [16:0] sat_d  [NC-1];
    logic [7:0]  bri_d  [NC-1];
    logic [14:0] hue_s;
    logic [16:0] sat_s;
    logic [7:0]  bri_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_s <= hue;
            sat_s <= saturation;
            bri_s <= brightness;
            hue_d[0] <= hue_s;
            sat_d[0] <= sat_s;
            bri_d[0] <= bri_s;
            for (int k = 1; k < NC - 1; k++)
            begin
                hue_d[k] <= hue_d[k-1];
                sat_d[k] <= sat_d[k-1];
                bri_d[k] <= bri_d[k-1];
            end
        end
    end

    rhcc_hsv2rgb u_rgb (
        .clk       (clk),
        .en        (en),
        .hue       (hue_d[NC-2]),
        .saturation(sat_d[NC-2]),
        .brightness(bri_d[NC-2]),
        .r         (cr),
        .g         (cg),
        .b         (cb)
    );

    always_comb
    begin
        od_next = '0;
        if (cw[NC].kind == KIND_TO_RGB)
        begin
            od_next[7:0]   = cr;
            od_next[15:8]  = cg;
            od_next[23:16] = cb;
        end
        else
        begin
            od_next[38:24] = cw[NC].hq[14:0];
            od_next[55:39] = cw[NC].sq;
            od_next[63:56] = cw[NC].v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= cv[NC];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            od_reg <= od_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:56] == 8'd0 || m_tdata[23:0] == 24'd0)
        else $error("both result groups populated");
endmodule
`default_nettype wire
